// File: hdl/sset_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sset_pkg
// Types and constants shared by the sorted set controller and datapath.
// ----------------------------------------------------------------------------
package sset_pkg;

    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_DELETE = 1'b1;

    localparam logic [2:0] ST_ADDED   = 3'd0;
    localparam logic [2:0] ST_PRESENT = 3'd1;
    localparam logic [2:0] ST_REMOVED = 3'd2;
    localparam logic [2:0] ST_ABSENT  = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] value;
    } cmd_in_t;

    typedef struct packed {
        logic [2:0] status;
        logic [6:0] element_count;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_COMPARE,
        S_SHIFT,
        S_DRAIN,
        S_PLACE
    } state_t;

    typedef struct packed {
        logic       load;
        logic       probe;
        logic       compare;
        logic       shift_init;
        logic       shift_step;
        logic       place;
        logic       commit;
        logic [2:0] commit_status;
    } dp_cmd_t;

    typedef struct packed {
        logic kind;
        logic search_done;
        logic found;
        logic full;
        logic shift_add_needed;
        logic shift_del_needed;
        logic shift_last;
    } dp_status_t;

endpackage
`default_nettype wire

// File: hdl/sset_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sset_datapath
// Entry memory, binary search registers, shift pointer and result register.
// ----------------------------------------------------------------------------
module sset_datapath #(
    parameter int SET_DEPTH = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire sset_pkg::cmd_in_t   command,
    input  wire sset_pkg::dp_cmd_t   ctl,
    output sset_pkg::dp_status_t     stat,
    output logic                     done,
    output sset_pkg::result_t        result
);
    import sset_pkg::*;

    localparam int AW = $clog2(SET_DEPTH);
    localparam int CW = $clog2(SET_DEPTH + 1);
    localparam int EW = (CW > 7) ? CW : 7;

    logic [31:0]        mem [SET_DEPTH];

    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      lo_reg, lo_next;
    logic [CW-1:0]      hi_reg, hi_next;
    logic [CW-1:0]      sp_reg, sp_next;
    logic               found_reg, found_next;
    logic               kind_reg, kind_next;
    logic signed [31:0] value_reg, value_next;
    logic [31:0]        rd_data_reg;
    logic               wr_pend_reg, wr_pend_next;
    logic [AW-1:0]      wr_addr_reg, wr_addr_next;
    logic               done_reg, done_next;
    result_t            result_reg, result_next;

    logic [CW:0]        mid_sum;
    logic [CW-1:0]      mid;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [31:0]        wr_data;
    logic [CW-1:0]      sp_dec;
    logic [CW-1:0]      sp_inc;
    logic [CW-1:0]      lo_inc;
    logic [CW-1:0]      count_dec;
    logic [EW-1:0]      count_ext;

    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = mid_sum[CW:1];
    assign sp_dec    = sp_reg - 1'b1;
    assign sp_inc    = sp_reg + 1'b1;
    assign lo_inc    = lo_reg + 1'b1;
    assign count_dec = count_reg - 1'b1;

    always_comb
    begin
        rd_en   = ctl.probe | ctl.shift_step;
        rd_addr = mid[AW-1:0];
        if (ctl.shift_step)
        begin
            rd_addr = (kind_reg == KIND_ADD) ? sp_dec[AW-1:0] : sp_reg[AW-1:0];
        end
    end

    always_comb
    begin
        wr_en   = wr_pend_reg | ctl.place;
        wr_addr = wr_addr_reg;
        wr_data = rd_data_reg;
        if (ctl.place)
        begin
            wr_addr = lo_reg[AW-1:0];
            wr_data = value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        count_next   = count_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        sp_next      = sp_reg;
        found_next   = found_reg;
        kind_next    = kind_reg;
        value_next   = value_reg;
        wr_pend_next = 1'b0;
        wr_addr_next = wr_addr_reg;
        done_next    = 1'b0;
        result_next  = result_reg;

        if (ctl.load)
        begin
            kind_next  = command.kind;
            value_next = command.value;
            lo_next    = '0;
            hi_next    = count_reg;
            found_next = 1'b0;
        end

        if (ctl.compare)
        begin
            if ($signed(rd_data_reg) < value_reg)
            begin
                lo_next = mid + 1'b1;
            end
            else
            begin
                hi_next = mid;
            end
            if (rd_data_reg == value_reg)
            begin
                found_next = 1'b1;
            end
        end

        if (ctl.shift_init)
        begin
            sp_next = (kind_reg == KIND_ADD) ? count_reg : lo_inc;
        end

        if (ctl.shift_step)
        begin
            wr_pend_next = 1'b1;
            if (kind_reg == KIND_ADD)
            begin
                wr_addr_next = sp_reg[AW-1:0];
                sp_next      = sp_dec;
            end
            else
            begin
                wr_addr_next = sp_dec[AW-1:0];
                sp_next      = sp_inc;
            end
        end

        if (ctl.commit)
        begin
            if (ctl.commit_status == ST_ADDED)
            begin
                count_next = count_reg + 1'b1;
            end
            else if (ctl.commit_status == ST_REMOVED)
            begin
                count_next = count_dec;
            end
            done_next          = 1'b1;
            count_ext          = EW'(count_next);
            result_next.status = ctl.commit_status;
            result_next.element_count = count_ext[6:0];
        end
        else
        begin
            count_ext = EW'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            wr_pend_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            wr_pend_reg <= wr_pend_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        sp_reg      <= sp_next;
        found_reg   <= found_next;
        kind_reg    <= kind_next;
        value_reg   <= value_next;
        wr_addr_reg <= wr_addr_next;
        result_reg  <= result_next;
    end

    assign stat.kind             = kind_reg;
    assign stat.search_done      = (lo_reg >= hi_reg);
    assign stat.found            = found_reg;
    assign stat.full             = (count_reg == CW'(SET_DEPTH));
    assign stat.shift_add_needed = (lo_reg < count_reg);
    assign stat.shift_del_needed = (lo_inc < count_reg);
    assign stat.shift_last       = (kind_reg == KIND_ADD) ? (sp_reg == lo_inc)
                                                          : (sp_reg == count_dec);

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

// File: hdl/sset_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sset_controller
// Sequencer for search, shift, placement and result commit.
// ----------------------------------------------------------------------------
module sset_controller (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire sset_pkg::dp_status_t stat,
    output sset_pkg::dp_cmd_t         ctl
);
    import sset_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (!stat.search_done)
                begin
                    state_next = S_COMPARE;
                end
                else if (stat.kind == KIND_ADD)
                begin
                    if (stat.found || stat.full)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (stat.shift_add_needed)
                    begin
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_PLACE;
                    end
                end
                else if (stat.found && stat.shift_del_needed)
                begin
                    state_next = S_SHIFT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_COMPARE:
            begin
                state_next = S_PROBE;
            end
            S_SHIFT:
            begin
                if (stat.shift_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = (stat.kind == KIND_ADD) ? S_PLACE : S_IDLE;
            end
            S_PLACE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl  = '0;
        busy = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                busy     = 1'b0;
                ctl.load = start;
            end
            S_PROBE:
            begin
                if (!stat.search_done)
                begin
                    ctl.probe = 1'b1;
                end
                else if (stat.kind == KIND_ADD)
                begin
                    if (stat.found)
                    begin
                        ctl.commit        = 1'b1;
                        ctl.commit_status = ST_PRESENT;
                    end
                    else if (stat.full)
                    begin
                        ctl.commit        = 1'b1;
                        ctl.commit_status = ST_FULL;
                    end
                    else if (stat.shift_add_needed)
                    begin
                        ctl.shift_init = 1'b1;
                    end
                end
                else if (!stat.found)
                begin
                    ctl.commit        = 1'b1;
                    ctl.commit_status = ST_ABSENT;
                end
                else if (stat.shift_del_needed)
                begin
                    ctl.shift_init = 1'b1;
                end
                else
                begin
                    ctl.commit        = 1'b1;
                    ctl.commit_status = ST_REMOVED;
                end
            end
            S_COMPARE:
            begin
                ctl.compare = 1'b1;
            end
            S_SHIFT:
            begin
                ctl.shift_step = 1'b1;
            end
            S_DRAIN:
            begin
                if (stat.kind == KIND_DELETE)
                begin
                    ctl.commit        = 1'b1;
                    ctl.commit_status = ST_REMOVED;
                end
            end
            S_PLACE:
            begin
                ctl.place         = 1'b1;
                ctl.commit        = 1'b1;
                ctl.commit_status = ST_ADDED;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: hdl/sorted_set_insert_delete.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_set_insert_delete
// Sorted set of distinct signed 32-bit values with add and delete commands.
// ----------------------------------------------------------------------------
// Usage: drive command (kind, value) and raise start while busy is low; the
// transaction is taken at that clock edge and busy rises the next cycle.
// Exactly one result per transaction appears on result with done high for a
// single cycle; result.status gives added, already present, removed, not
// present or full, and result.element_count the count after the command.
// A binary search over the held entries alternates a probe state, which
// reads the entry memory, with a compare state, and ends in a decision in
// the probe state, paced by the single registered read port of the entry
// memory. An add or delete that moves entries then streams one entry per
// cycle through that port, and an add then places the value. The result is
// registered and appears in the cycle after the last step; busy is low
// again by then, so the next transaction may start in the same cycle as
// done.
// Reset empties the set at once; no memory clearing pass is needed. The
// receiver cannot stall: a result not taken in its done cycle is lost.
// ----------------------------------------------------------------------------
module sorted_set_insert_delete #(
    parameter int SET_DEPTH = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire sset_pkg::cmd_in_t command,
    output logic                   done,
    output sset_pkg::result_t      result
);
    import sset_pkg::*;

    dp_cmd_t    ctl;
    dp_status_t stat;

    sset_controller u_controller (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .ctl   (ctl)
    );

    sset_datapath #(
        .SET_DEPTH (SET_DEPTH)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .command (command),
        .ctl     (ctl),
        .stat    (stat),
        .done    (done),
        .result  (result)
    );

endmodule
`default_nettype wire

// File: sim/tb_sorted_set_insert_delete.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_set_insert_delete
// Self-checking testbench for the sorted set add/delete block.
// ----------------------------------------------------------------------------
// A directed sequence covers the signed extremes, duplicate adds, deletes of
// missing values and removal at head, middle and tail. Random phases then
// mix adds and deletes drawn from held entries, a narrow value band, the
// extremes and full 32-bit noise, and fill the set to capacity to exercise
// full rejection before draining it again. A local copy of the set predicts
// each transaction's status and count; the monitor compares every done
// strobe against the oldest prediction. The sender idles at three rates.
// ----------------------------------------------------------------------------
module tb_sorted_set_insert_delete;
    import sset_pkg::*;

    localparam int SET_DEPTH    = 64;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int DRAIN_CYCLES = 200;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

    logic    clk;
    logic    rst_n   = 1'b0;
    logic    start   = 1'b0;
    cmd_in_t command = '0;
    logic    busy;
    logic    done;
    result_t result;

    logic signed [31:0] set_values [SET_DEPTH];
    int                 set_size = 0;

    result_t pending_results [$];
    int      idle_pct      = 0;
    int      sent_count    = 0;
    int      checked_count = 0;
    int      error_count   = 0;
    int      cycle_count   = 0;
    int      status_tally [0:7];

    sorted_set_insert_delete #(
        .SET_DEPTH (SET_DEPTH)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .command (command),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic result_t apply_set_command(input cmd_in_t cmd);
        logic signed [31:0] v;
        int                 pos;
        logic               held;
        result_t            r;
        v   = cmd.value;
        pos = 0;
        while (pos < set_size && set_values[pos] < v)
            pos++;
        held = (pos < set_size) && (set_values[pos] == v);
        if (cmd.kind == KIND_ADD)
        begin
            if (held)
                r.status = ST_PRESENT;
            else if (set_size >= SET_DEPTH)
                r.status = ST_FULL;
            else
            begin
                for (int i = set_size; i > pos; i--)
                    set_values[i] = set_values[i - 1];
                set_values[pos] = v;
                set_size++;
                r.status = ST_ADDED;
            end
        end
        else
        begin
            if (held)
            begin
                for (int i = pos; i + 1 < set_size; i++)
                    set_values[i] = set_values[i + 1];
                set_size--;
                r.status = ST_REMOVED;
            end
            else
                r.status = ST_ABSENT;
        end
        r.element_count = set_size[6:0];
        return r;
    endfunction

    function automatic logic signed [31:0] pick_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 30 && set_size > 0)
            return set_values[$urandom_range(set_size - 1)];
        else if (sel < 60)
            return $signed(32'($urandom_range(63))) - 32'sd32;
        else if (sel < 70)
        begin
            case ($urandom_range(5))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return VAL_MIN + 32'sd1;
                3: return VAL_MAX - 32'sd1;
                4: return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        return $signed($urandom);
    endfunction

    task automatic send_command(input logic kind, input logic signed [31:0] value);
        cmd_in_t cmd;
        cmd.kind  = kind;
        cmd.value = value;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        command <= cmd;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(apply_set_command(cmd));
        sent_count++;
    endtask

    task automatic report_mismatch(input string what, input int want, input int got);
        error_count++;
        $display("%0t: %s mismatch expected %0d actual %0d", $time, what, want, got);
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            status_tally[result.status]++;
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, status", -1, int'(result.status));
            else
            begin
                want = pending_results.pop_front();
                checked_count++;
                if (result.status !== want.status)
                    report_mismatch("status", int'(want.status), int'(result.status));
                if (result.element_count !== want.element_count)
                    report_mismatch("element_count", int'(want.element_count),
                                    int'(result.element_count));
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic test_directed();
        send_command(KIND_DELETE, 32'sd0);
        send_command(KIND_ADD, 32'sd0);
        send_command(KIND_ADD, VAL_MIN);
        send_command(KIND_ADD, VAL_MAX);
        send_command(KIND_ADD, -32'sd1);
        send_command(KIND_ADD, 32'sd1);
        send_command(KIND_ADD, 32'sd0);
        send_command(KIND_ADD, VAL_MIN);
        send_command(KIND_ADD, VAL_MAX);
        send_command(KIND_DELETE, 32'sd5);
        send_command(KIND_DELETE, VAL_MIN + 32'sd1);
        send_command(KIND_ADD, 32'sh5555_5555);
        send_command(KIND_ADD, 32'shAAAA_AAAA);
        send_command(KIND_DELETE, VAL_MIN);
        send_command(KIND_DELETE, VAL_MAX);
        send_command(KIND_DELETE, 32'sd0);
        send_command(KIND_DELETE, 32'sd0);
        send_command(KIND_DELETE, -32'sd1);
        send_command(KIND_DELETE, 32'sd1);
        send_command(KIND_DELETE, 32'sh5555_5555);
        send_command(KIND_DELETE, 32'shAAAA_AAAA);
        send_command(KIND_DELETE, VAL_MAX);
    endtask

    task automatic test_random_mix(input int count);
        int add_pct;
        repeat (count)
        begin
            add_pct = (set_size < SET_DEPTH / 2) ? 60 : 40;
            send_command(($urandom_range(99) < add_pct) ? KIND_ADD : KIND_DELETE,
                         pick_value());
        end
    endtask

    task automatic test_fill_and_drain();
        int guard;
        guard = 0;
        while (set_size < SET_DEPTH && guard < 4 * SET_DEPTH)
        begin
            send_command(KIND_ADD, ($urandom_range(3) == 0) ? pick_value()
                                                             : $signed($urandom));
            guard++;
        end
        repeat (12)
        begin
            if ($urandom_range(2) == 0 && set_size > 0)
                send_command(KIND_ADD, set_values[$urandom_range(set_size - 1)]);
            else
                send_command(KIND_ADD, $signed($urandom));
        end
        send_command(KIND_DELETE, $signed($urandom));
        send_command(KIND_ADD, $signed($urandom));
        while (set_size > 0)
        begin
            if ($urandom_range(4) == 0)
                send_command(KIND_DELETE, pick_value());
            else
                send_command(KIND_DELETE, set_values[$urandom_range(set_size - 1)]);
        end
    endtask

    initial
    begin
        foreach (status_tally[i])
            status_tally[i] = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 12;
        test_directed();
        test_random_mix(250);
        test_fill_and_drain();

        idle_pct = 88;
        test_random_mix(250);
        test_fill_and_drain();

        idle_pct = 0;
        test_random_mix(250);
        test_fill_and_drain();

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending_results.size() != 0)
            report_mismatch("outstanding results, count", 0, pending_results.size());

        $display("Covered %0d transactions, %0d results checked, %0d errors",
                 sent_count, checked_count, error_count);
        $display("Status seen: added %0d present %0d removed %0d absent %0d full %0d",
                 status_tally[ST_ADDED], status_tally[ST_PRESENT],
                 status_tally[ST_REMOVED], status_tally[ST_ABSENT],
                 status_tally[ST_FULL]);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
